// ===== rtl/core/pcsr_pkg.sv =====
// Shared types, codes and widths of the pattern CSR sparse matrix-vector block.
`timescale 1ns / 1ps
package pcsr_pkg;

  localparam int unsigned Q_W   = 32;
  localparam int unsigned ACC_W = 48;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned REG_W = 2;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_NZ    = 2'd1;
  localparam op_t OP_EMPTY = 2'd2;

  typedef logic [REG_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_NONZERO = 2'd0;
  localparam reg_idx_t REG_SCALED  = 2'd1;
  localparam reg_idx_t REG_ALPHA   = 2'd2;
  localparam reg_idx_t REG_BETA    = 2'd3;

  localparam logic signed [Q_W-1:0] NONZERO_RST = 32'sd65536;
  localparam logic signed [Q_W-1:0] ALPHA_RST   = 32'sd65536;
  localparam logic signed [Q_W-1:0] BETA_RST    = 32'sd0;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] a;
    logic signed [Q_W-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic signed [ACC_W-1:0] result;
  } mul_rsp_t;

endpackage

// ===== rtl/core/pattern_csr_spmv.sv =====
// Top level: pattern-only CSR sparse matrix-vector product with a shared multiplier.
//
//  channel | dir | handshake              | content
//  in_     | in  | in_tvalid / in_tready  | tdata vector/column/old value, tuser op+eom, tlast eor
//  out_    | out | out_tvalid / out_tready| tdata row index+value, tuser saturated
//  cfg_    | in  | cfg_we                 | cfg_addr register index, cfg_wdata value
//
//  A vector load leaves the input ready; a nonzero inside a row takes a store read and an accumulate.
//  A row end runs one product in plain mode and three in scaled mode; an empty row skips the accumulate:
//  each product runs through the single 24x32 multiplier, two passes per product.
//  Reset (synchronous, active low) clears row sum, row counter, handshakes; registers load reset values.
//  A finished result waits in the output register; a new item is taken meanwhile and
//  stalls only when its own result is ready while the previous one is still held.
`timescale 1ns / 1ps
module pattern_csr_spmv #(
  parameter int unsigned VECTOR_DEPTH = 1024,
  parameter int unsigned ROW_LIMIT    = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vector_index[9:0], vector_value[41:10], column_index[51:42], old_output[83:52], zero pad
  input  logic [87:0]  in_tdata,
  // operation[1:0], end_of_matrix[2]
  input  logic [2:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index[15:0], output_value[47:16]
  output logic [47:0]  out_tdata,
  // saturated[0]
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int unsigned AW    = $clog2(VECTOR_DEPTH);
  localparam int unsigned CNT_W = $clog2(ROW_LIMIT);
  localparam logic [CNT_W:0] ROW_LIM_V = (CNT_W + 1)'(ROW_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_MUL_P,
    S_MUL_A,
    S_MUL_B,
    S_FINAL,
    S_EMIT
  } state_t;

  state_t state_r;

  logic signed [31:0] nz_r;
  logic               scaled_r;
  logic signed [31:0] alpha_r;
  logic signed [31:0] beta_r;

  logic signed [47:0] row_sum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               col_ok_r;
  logic               eor_r;
  logic               eom_r;
  logic signed [31:0] old_r;
  logic               start_r;
  logic signed [47:0] prod_r;
  logic signed [47:0] term_a_r;
  logic signed [47:0] term_b_r;
  logic               sat_r;
  logic signed [31:0] res_r;
  logic               out_valid_r;
  logic [15:0]        out_row_r;
  logic [31:0]        out_val_r;
  logic               out_sat_r;

  pcsr_pkg::op_t      in_op;
  logic [9:0]         in_vidx;
  logic [31:0]        in_vval;
  logic [9:0]         in_col;
  logic               in_acc;
  logic               vidx_ok;
  logic               col_ok;
  logic [31:0]        rd_data;

  pcsr_pkg::mul_req_t mul_req;
  pcsr_pkg::mul_rsp_t mul_rsp;

  logic signed [48:0] acc_wide;
  logic signed [47:0] acc_nxt;
  logic signed [48:0] fin_wide;
  logic               fin_hi;
  logic               fin_lo;
  logic signed [31:0] fin_nxt;
  logic [CNT_W:0]     cnt_inc;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               out_free;

  always_comb begin
    in_op   = in_tuser[1:0];
    in_vidx = in_tdata[9:0];
    in_vval = in_tdata[41:10];
    in_col  = in_tdata[51:42];
    in_acc  = in_tvalid && in_tready;
    vidx_ok = (32'(in_vidx) < VECTOR_DEPTH);
    col_ok  = (32'(in_col) < VECTOR_DEPTH);
  end

  pcsr_vec_mem #(
    .DEPTH (VECTOR_DEPTH),
    .AW    (AW)
  ) u_vec_mem (
    .clk     (clk),
    .wr_en   (in_acc && (in_op == pcsr_pkg::OP_LOAD) && vidx_ok),
    .wr_addr (AW'(in_vidx)),
    .wr_data (in_vval),
    .rd_en   (in_acc && (in_op == pcsr_pkg::OP_NZ)),
    .rd_addr (AW'(in_col)),
    .rd_data (rd_data)
  );

  always_comb begin
    mul_req.start = start_r;
    case (state_r)
      S_MUL_A: begin
        mul_req.a = prod_r;
        mul_req.b = alpha_r;
      end
      S_MUL_B: begin
        mul_req.a = 48'(old_r);
        mul_req.b = beta_r;
      end
      default: begin
        mul_req.a = row_sum_r;
        mul_req.b = nz_r;
      end
    endcase
  end

  pcsr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_comb begin
    acc_wide = {row_sum_r[47], row_sum_r}
             + (col_ok_r ? 49'(signed'(rd_data)) : 49'sd0);
    if (acc_wide[48] != acc_wide[47]) begin
      acc_nxt = acc_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      acc_nxt = acc_wide[47:0];
    end

    fin_wide = scaled_r ? ({term_a_r[47], term_a_r} + {term_b_r[47], term_b_r})
                        : {prod_r[47], prod_r};
    fin_hi = !fin_wide[48] && (fin_wide[47:31] != 17'h00000);
    fin_lo = fin_wide[48] && (fin_wide[47:31] != 17'h1FFFF);
    if (fin_hi) begin
      fin_nxt = 32'sh7FFF_FFFF;
    end else if (fin_lo) begin
      fin_nxt = 32'sh8000_0000;
    end else begin
      fin_nxt = fin_wide[31:0];
    end

    cnt_inc = {1'b0, cnt_r} + 1'b1;
    cnt_nxt = (eom_r || (cnt_inc >= ROW_LIM_V)) ? '0 : cnt_inc[CNT_W-1:0];
    out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r     <= pcsr_pkg::NONZERO_RST;
      scaled_r <= 1'b0;
      alpha_r  <= pcsr_pkg::ALPHA_RST;
      beta_r   <= pcsr_pkg::BETA_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pcsr_pkg::REG_NONZERO: nz_r     <= cfg_wdata;
        pcsr_pkg::REG_SCALED:  scaled_r <= cfg_wdata[0];
        pcsr_pkg::REG_ALPHA:   alpha_r  <= cfg_wdata;
        pcsr_pkg::REG_BETA:    beta_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_sum_r   <= '0;
      cnt_r       <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= ((state_r == S_IDLE) && in_acc && (in_op == pcsr_pkg::OP_EMPTY))
              || ((state_r == S_ACC) && eor_r)
              || ((state_r == S_MUL_P) && mul_rsp.done && scaled_r)
              || ((state_r == S_MUL_A) && mul_rsp.done);
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            col_ok_r <= col_ok;
            eor_r    <= in_tlast;
            eom_r    <= in_tuser[2];
            old_r    <= in_tdata[83:52];
            sat_r    <= 1'b0;
            case (in_op)
              pcsr_pkg::OP_NZ: begin
                state_r <= S_ACC;
              end
              pcsr_pkg::OP_EMPTY: begin
                row_sum_r <= '0;
                state_r   <= S_MUL_P;
              end
              default: begin
              end
            endcase
          end
        end
        S_ACC: begin
          row_sum_r <= acc_nxt;
          if (eor_r) begin
            state_r <= S_MUL_P;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_MUL_P: begin
          if (mul_rsp.done) begin
            prod_r <= mul_rsp.result;
            sat_r  <= sat_r | mul_rsp.sat;
            if (scaled_r) begin
              state_r <= S_MUL_A;
            end else begin
              state_r <= S_FINAL;
            end
          end
        end
        S_MUL_A: begin
          if (mul_rsp.done) begin
            term_a_r <= mul_rsp.result;
            sat_r    <= sat_r | mul_rsp.sat;
            state_r  <= S_MUL_B;
          end
        end
        S_MUL_B: begin
          if (mul_rsp.done) begin
            term_b_r <= mul_rsp.result;
            sat_r    <= sat_r | mul_rsp.sat;
            state_r  <= S_FINAL;
          end
        end
        S_FINAL: begin
          res_r   <= fin_nxt;
          sat_r   <= sat_r | fin_hi | fin_lo;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= 16'(cnt_r);
            out_val_r   <= res_r;
            out_sat_r   <= sat_r;
            cnt_r       <= cnt_nxt;
            row_sum_r   <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r, out_row_r};
  assign out_tuser  = out_sat_r;

endmodule

// ===== rtl/core/pcsr_vec_mem.sv =====
// Dense vector store: one write port, one read port with registered data.
`timescale 1ns / 1ps
module pcsr_vec_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [pcsr_pkg::Q_W-1:0]   wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [pcsr_pkg::Q_W-1:0]   rd_data
);

  logic [pcsr_pkg::Q_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/pcsr_mul.sv =====
// Iterative Q16.16 multiplier: 48x32 product in two 24x32 passes, rounded and clipped.
`timescale 1ns / 1ps
module pcsr_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  pcsr_pkg::mul_req_t  req,
  output pcsr_pkg::mul_rsp_t  rsp
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_SUM,
    M_CLIP
  } mstate_t;

  mstate_t     state_r;
  logic        neg_r;
  logic [47:0] ma_r;
  logic [31:0] mb_r;
  logic [55:0] plo_r;
  logic [55:0] phi_r;
  logic [63:0] mag_r;

  logic [23:0] part_sel;
  logic [55:0] part_prod;
  logic [56:0] rnd_nxt;
  logic [63:0] mag_nxt;
  logic [63:0] lim;
  logic [47:0] clip_mag;
  logic        clip_sat;

  always_comb begin
    part_sel  = (state_r == M_HI) ? ma_r[47:24] : ma_r[23:0];
    part_prod = 56'(part_sel) * 56'(mb_r);
    rnd_nxt   = {1'b0, plo_r} + 57'h8000;
    mag_nxt   = {phi_r, 8'b0} + 64'(rnd_nxt[56:16]);
    lim       = neg_r ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    clip_sat  = (mag_r > lim);
    clip_mag  = clip_sat ? lim[47:0] : mag_r[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state_r == M_CLIP);
      case (state_r)
        M_IDLE: begin
          if (req.start) begin
            neg_r   <= req.a[47] ^ req.b[31];
            ma_r    <= req.a[47] ? (~req.a + 48'd1) : req.a;
            mb_r    <= req.b[31] ? (~req.b + 32'd1) : req.b;
            state_r <= M_LO;
          end
        end
        M_LO: begin
          plo_r   <= part_prod;
          state_r <= M_HI;
        end
        M_HI: begin
          phi_r   <= part_prod;
          state_r <= M_SUM;
        end
        M_SUM: begin
          mag_r   <= mag_nxt;
          state_r <= M_CLIP;
        end
        M_CLIP: begin
          rsp.result <= neg_r ? (~clip_mag + 48'd1) : clip_mag;
          rsp.sat    <= clip_sat;
          state_r    <= M_IDLE;
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pcsr_checker.sv =====
// Port-level checks on the sparse matrix-vector block, bound to the top level.
`timescale 1ns / 1ps
module pcsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed or dropped while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_nz_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[1:0] == pcsr_pkg::OP_NZ) |=> !in_tready)
    else $error("ready while accumulating a nonzero");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[1:0] == pcsr_pkg::OP_LOAD) |=> in_tready)
    else $error("vector load did not complete in one cycle");

endmodule

bind pattern_csr_spmv pcsr_checker u_pcsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb_pattern_csr_spmv.sv =====
// Self-checking testbench for the pattern CSR sparse matrix-vector block.
`timescale 1ns / 1ps
module tb_pattern_csr_spmv;

  localparam int unsigned VEC_DEPTH   = 1024;
  localparam int unsigned SETTLE      = 30;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam pcsr_pkg::op_t OP_IGNORED = 2'd3;
  localparam logic signed [pcsr_pkg::ACC_W-1:0] ACC_HI =
    {1'b0, {(pcsr_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [pcsr_pkg::ACC_W-1:0] ACC_LO =
    {1'b1, {(pcsr_pkg::ACC_W-1){1'b0}}};

  typedef logic [pcsr_pkg::IDX_W-1:0] col_idx_t;

  typedef struct {
    pcsr_pkg::op_t              op;
    logic [pcsr_pkg::IDX_W-1:0] vidx;
    logic [pcsr_pkg::Q_W-1:0]   vval;
    logic [pcsr_pkg::IDX_W-1:0] col;
    logic                       eor;
    logic                       eom;
    logic [pcsr_pkg::Q_W-1:0]   old;
  } request_t;

  typedef struct {
    logic [pcsr_pkg::ROW_W-1:0] row;
    logic [pcsr_pkg::Q_W-1:0]   value;
    logic                       sat;
  } row_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [87:0]        in_tdata = '0;
  logic [2:0]         in_tuser = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [47:0]        out_tdata;
  logic               out_tuser;
  logic               cfg_we = 1'b0;
  pcsr_pkg::reg_idx_t cfg_addr = pcsr_pkg::REG_NONZERO;
  logic [31:0]        cfg_wdata = '0;

  logic signed [pcsr_pkg::Q_W-1:0]   cur_nonzero;
  logic signed [pcsr_pkg::Q_W-1:0]   cur_alpha;
  logic signed [pcsr_pkg::Q_W-1:0]   cur_beta;
  logic                              cur_scaled;
  logic [pcsr_pkg::Q_W-1:0]          cur_vector [VEC_DEPTH];
  logic signed [pcsr_pkg::ACC_W-1:0] cur_row_sum;
  logic [pcsr_pkg::ROW_W-1:0]        cur_row_ctr;

  row_result_t expected_rows[$];
  row_result_t exp_row;
  bit          loaded [VEC_DEPTH];
  int unsigned loaded_cols[$];
  int unsigned tx_gap_pct = 9;
  int unsigned rx_stall_pct = 46;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  pattern_csr_spmv u_top (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pattern_csr_spmv test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected row result: row_index %0d output_value %0d",
               out_tdata[15:0], $signed(out_tdata[47:16]));
        err_count++;
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_tdata[15:0] !== exp_row.row) begin
          $error("row_index expected %0d got %0d", exp_row.row, out_tdata[15:0]);
          err_count++;
        end
        if (out_tdata[47:16] !== exp_row.value) begin
          $error("output_value expected %0d got %0d",
                 $signed(exp_row.value), $signed(out_tdata[47:16]));
          err_count++;
        end
        if (out_tuser !== exp_row.sat) begin
          $error("saturated expected %0d got %0d", exp_row.sat, out_tuser);
          err_count++;
        end
      end
    end
  end

  // Q16.16 product, rounded half away from zero, clipped to the accumulator range
  function automatic logic signed [pcsr_pkg::ACC_W-1:0] q16_mul(
      input logic signed [pcsr_pkg::ACC_W-1:0] a,
      input logic signed [pcsr_pkg::Q_W-1:0]   b,
      inout logic                              clipped);
    logic signed [95:0] wa;
    logic signed [95:0] wb;
    logic [95:0]        ma;
    logic [95:0]        mb;
    logic [95:0]        prod;
    logic [95:0]        lim;
    logic               neg;
    wa = 96'(a);
    wb = 96'(b);
    neg = wa[95] ^ wb[95];
    ma = wa[95] ? -wa : wa;
    mb = wb[95] ? -wb : wb;
    prod = (ma * mb + 96'h8000) >> 16;
    lim = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
    if (prod > lim) begin
      prod = lim;
      clipped = 1'b1;
    end
    return neg ? -prod[pcsr_pkg::ACC_W-1:0] : prod[pcsr_pkg::ACC_W-1:0];
  endfunction

  task automatic emit_row(input logic signed [pcsr_pkg::ACC_W-1:0] sum,
                          input logic [pcsr_pkg::Q_W-1:0] old, input logic last_row);
    logic                              clipped;
    logic signed [pcsr_pkg::ACC_W-1:0] prod;
    logic signed [63:0]                alpha_term;
    logic signed [63:0]                beta_term;
    logic signed [63:0]                total;
    row_result_t                       res;
    clipped = 1'b0;
    prod = q16_mul(sum, cur_nonzero, clipped);
    if (cur_scaled) begin
      alpha_term = 64'(q16_mul(prod, cur_alpha, clipped));
      beta_term = 64'(q16_mul(48'($signed(old)), cur_beta, clipped));
      total = alpha_term + beta_term;
    end else begin
      total = 64'(prod);
    end
    if (total > 64'sh7FFF_FFFF) begin
      total = 64'sh7FFF_FFFF;
      clipped = 1'b1;
    end else if (total < -64'sh8000_0000) begin
      total = -64'sh8000_0000;
      clipped = 1'b1;
    end
    res.row = cur_row_ctr;
    res.value = total[pcsr_pkg::Q_W-1:0];
    res.sat = clipped;
    expected_rows.push_back(res);
    cur_row_ctr = last_row ? '0 : cur_row_ctr + 1'b1;
    cur_row_sum = '0;
  endtask

  task automatic apply_request(input request_t r);
    logic signed [63:0] s;
    case (r.op)
      pcsr_pkg::OP_LOAD: begin
        cur_vector[r.vidx] = r.vval;
      end
      pcsr_pkg::OP_NZ: begin
        s = 64'(cur_row_sum);
        s = s + 64'($signed(cur_vector[r.col]));
        if (s > 64'(ACC_HI)) s = 64'(ACC_HI);
        if (s < 64'(ACC_LO)) s = 64'(ACC_LO);
        cur_row_sum = s[pcsr_pkg::ACC_W-1:0];
        if (r.eor) emit_row(cur_row_sum, r.old, r.eom);
      end
      pcsr_pkg::OP_EMPTY: begin
        emit_row('0, r.old, r.eom);
      end
      default: ;
    endcase
  endtask

  task automatic send_req(input request_t r);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, r.old, r.col, r.vval, r.vidx};
    in_tuser  <= {r.eom, r.op};
    in_tlast  <= r.eor;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(r);
    if (r.op == pcsr_pkg::OP_LOAD && !loaded[r.vidx]) begin
      loaded[r.vidx] = 1'b1;
      loaded_cols.push_back(32'(r.vidx));
    end
  endtask

  // hold the input until every row result has come back, then let the pipeline empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input pcsr_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pcsr_pkg::REG_NONZERO: cur_nonzero = val;
      pcsr_pkg::REG_SCALED:  cur_scaled = val[0];
      pcsr_pkg::REG_ALPHA:   cur_alpha = val;
      pcsr_pkg::REG_BETA:    cur_beta = val;
      default: ;
    endcase
  endtask

  function automatic logic [pcsr_pkg::Q_W-1:0] rand_q16();
    logic [pcsr_pkg::Q_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2, 3: v = $urandom;
      default: v = $urandom_range(0, 32'h60000) - 32'h30000;
    endcase
    return v;
  endfunction

  function automatic request_t load_req(input int unsigned idx,
                                        input logic [pcsr_pkg::Q_W-1:0] val);
    request_t r;
    r.op = pcsr_pkg::OP_LOAD;
    r.vidx = col_idx_t'(idx);
    r.vval = val;
    r.col = col_idx_t'($urandom);
    r.eor = 1'($urandom_range(0, 1));
    r.eom = 1'($urandom_range(0, 1));
    r.old = $urandom;
    return r;
  endfunction

  function automatic request_t nz_req(input int unsigned col, input logic eor, input logic eom,
                                      input logic [pcsr_pkg::Q_W-1:0] old);
    request_t r;
    r.op = pcsr_pkg::OP_NZ;
    r.vidx = col_idx_t'($urandom);
    r.vval = $urandom;
    r.col = col_idx_t'(col);
    r.eor = eor;
    r.eom = eom;
    r.old = old;
    return r;
  endfunction

  function automatic request_t empty_req(input logic eom, input logic [pcsr_pkg::Q_W-1:0] old);
    request_t r;
    r = nz_req($urandom_range(0, VEC_DEPTH - 1), 1'($urandom_range(0, 1)), eom, old);
    r.op = pcsr_pkg::OP_EMPTY;
    return r;
  endfunction

  function automatic int unsigned pick_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  task automatic test_vector_load();
    send_req(load_req(0, 32'h7FFF_FFFF));
    send_req(load_req(VEC_DEPTH - 1, 32'h8000_0000));
    send_req(load_req(1, 32'h0001_0000));
    send_req(load_req(2, 32'hFFFF_0000));
    send_req(load_req(512, 32'h0001_8000));
  endtask

  task automatic test_plain_rows();
    request_t r;
    send_req(nz_req(0, 1'b1, 1'b0, 32'h0));
    send_req(nz_req(VEC_DEPTH - 1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_req(nz_req(1, 1'b0, 1'b0, 32'h0));
    send_req(nz_req(2, 1'b0, 1'b0, 32'h0));
    send_req(nz_req(512, 1'b1, 1'b0, 32'h0));
    send_req(empty_req(1'b0, 32'h1234_5678));
    send_req(empty_req(1'b1, 32'h0));
    // end of matrix without a row end: drop the flag
    send_req(nz_req(1, 1'b0, 1'b1, 32'h0));
    send_req(nz_req(2, 1'b1, 1'b0, 32'h0));
    r = empty_req(1'b1, 32'h0);
    r.op = OP_IGNORED;
    r.eor = 1'b1;
    send_req(r);
    send_req(empty_req(1'b0, 32'h0));
  endtask

  task automatic test_product_clip();
    drain();
    write_reg(pcsr_pkg::REG_NONZERO, 32'h7FFF_FFFF);
    repeat (3) send_req(nz_req(0, 1'b0, 1'b0, 32'h0));
    send_req(nz_req(0, 1'b1, 1'b0, 32'h0));
    send_req(nz_req(512, 1'b1, 1'b0, 32'h0));
    drain();
    write_reg(pcsr_pkg::REG_NONZERO, 32'h8000_0000);
    repeat (3) send_req(nz_req(VEC_DEPTH - 1, 1'b0, 1'b0, 32'h0));
    send_req(nz_req(VEC_DEPTH - 1, 1'b1, 1'b0, 32'h0));
    send_req(nz_req(0, 1'b1, 1'b1, 32'h0));
  endtask

  task automatic test_scaled_rows();
    drain();
    write_reg(pcsr_pkg::REG_NONZERO, 32'h0001_0000);
    write_reg(pcsr_pkg::REG_SCALED, 32'h1);
    write_reg(pcsr_pkg::REG_ALPHA, 32'h8000_0000);
    write_reg(pcsr_pkg::REG_BETA, 32'h7FFF_FFFF);
    send_req(empty_req(1'b0, 32'h7FFF_FFFF));
    send_req(empty_req(1'b1, 32'h8000_0000));
    send_req(nz_req(1, 1'b1, 1'b0, 32'h0001_0000));
    drain();
    write_reg(pcsr_pkg::REG_ALPHA, 32'h0001_8000);
    write_reg(pcsr_pkg::REG_BETA, 32'hFFFF_8000);
    send_req(nz_req(512, 1'b0, 1'b0, 32'h0));
    send_req(nz_req(2, 1'b1, 1'b0, 32'h0003_0000));
    send_req(empty_req(1'b0, 32'h0000_8001));
  endtask

  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    logic        last;
    logic        eom;
    request_t    r;
    drain();
    tx_gap_pct = gap_pct;
    rx_stall_pct = stall_pct;
    write_reg(pcsr_pkg::REG_NONZERO, rand_q16());
    write_reg(pcsr_pkg::REG_SCALED, $urandom_range(0, 1));
    write_reg(pcsr_pkg::REG_ALPHA, rand_q16());
    write_reg(pcsr_pkg::REG_BETA, rand_q16());
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          last = (k == len - 1);
          eom = last ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
          send_req(nz_req(pick_col(), last, eom, rand_q16()));
        end
        sent += len;
      end else if (kind < 80) begin
        len = $urandom_range(1, 4);
        repeat (len) send_req(load_req($urandom_range(0, VEC_DEPTH - 1), rand_q16()));
        sent += len;
      end else if (kind < 88) begin
        send_req(empty_req($urandom_range(0, 3) == 0, rand_q16()));
        sent++;
      end else if (kind < 95) begin
        // partial row cut off by an empty row: drop the partial sum
        len = $urandom_range(1, 3);
        repeat (len) send_req(nz_req(pick_col(), 1'b0, 1'($urandom_range(0, 1)), rand_q16()));
        send_req(empty_req($urandom_range(0, 3) == 0, rand_q16()));
        sent += len + 1;
      end else if (kind < 98) begin
        r = empty_req(1'($urandom_range(0, 1)), $urandom);
        r.op = OP_IGNORED;
        send_req(r);
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    cur_nonzero = pcsr_pkg::NONZERO_RST;
    cur_alpha = pcsr_pkg::ALPHA_RST;
    cur_beta = pcsr_pkg::BETA_RST;
    cur_scaled = 1'b0;
    cur_row_sum = '0;
    cur_row_ctr = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_vector_load();
    test_plain_rows();
    test_product_clip();
    test_scaled_rows();
    test_random_traffic(9, 46, 450);
    test_random_traffic(46, 9, 450);
    test_random_traffic(0, 0, 450);
    drain();
    if (err_count == 0) begin
      $display("pattern_csr_spmv test passed");
    end else begin
      $display("pattern_csr_spmv test failed");
    end
    $finish;
  end

endmodule
